### hdl/tmrs_pkg.sv
package tmrs_pkg;

   // Field widths
   localparam int ENG_CNT_W = 4;
   localparam int HOLD_W    = 16;
   localparam int SPEED_W   = 8;
   localparam int ENG_IDX_W = 3;
   localparam int REQ_SPD_W = 10;
   localparam int MIX_W     = REQ_SPD_W + 1;   // sum or difference of two requests
   localparam int SRV_W     = ENG_CNT_W + 1;   // served engine count, up to 15
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = HOLD_W;

   // Reset values of the control registers
   localparam logic [ENG_CNT_W-1:0] ENG_CNT_RST = ENG_CNT_W'(3);
   localparam logic [HOLD_W-1:0]    HOLD_RST    = HOLD_W'(2000);

   // Largest magnitude that a target may take
   localparam int TARGET_LIMIT = 255;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENGINE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS   = 1'b1;

   typedef enum logic {
      OP_COMMAND = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_STOP  = 2'd0,
      MODE_MOVE  = 2'd1,
      MODE_YAW   = 2'd2,
      MODE_PITCH = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_SPEED     = 1'b0,
      KIND_DIRECTION = 1'b1
   } kind_type;

   typedef struct packed {
      op_type                op;
      mode_type              mode;
      logic [REQ_SPD_W-1:0]  vertical_speed;
      logic [REQ_SPD_W-1:0]  move_speed;
      logic [REQ_SPD_W-1:0]  rotate_speed;
   } req_item_type;

   typedef struct packed {
      kind_type              write_kind;
      logic [ENG_IDX_W-1:0]  engine_index;
      logic [SPEED_W-1:0]    write_value;
   } rsp_item_type;

endpackage

### hdl/tmrs_ifs.sv
interface tmrs_req_if;
   import tmrs_pkg::*;

   logic                  valid;
   logic                  ready;
   op_type                op;
   mode_type              mode;
   logic [REQ_SPD_W-1:0]  vertical_speed;
   logic [REQ_SPD_W-1:0]  move_speed;
   logic [REQ_SPD_W-1:0]  rotate_speed;

   modport source (
      output valid, op, mode, vertical_speed, move_speed, rotate_speed,
      input  ready
   );
   modport sink (
      input  valid, op, mode, vertical_speed, move_speed, rotate_speed,
      output ready
   );
endinterface

interface tmrs_rsp_if;
   import tmrs_pkg::*;

   logic                  valid;
   logic                  ready;
   kind_type              write_kind;
   logic [ENG_IDX_W-1:0]  engine_index;
   logic [SPEED_W-1:0]    write_value;

   modport source (
      output valid, write_kind, engine_index, write_value,
      input  ready
   );
   modport sink (
      input  valid, write_kind, engine_index, write_value,
      output ready
   );
endinterface

### hdl/thruster_mix_reverse_scheduler.sv
// Thruster mixer and reverse-aware write scheduler. Each transfer on req_ch is
// either a command (op 0), which mixes the vertical, move and rotate requests
// into target magnitude and direction for engines 0 to 2 (stop zeroes every
// served engine; a target outside +/-255 is dropped and the old one kept), or
// a tick (op 1), which bumps the saturating per-engine hold counters, steps
// the round-robin pointer over the served engines and sends at most one write
// on rsp_ch for the engine it lands on: a pending direction change once
// reverse_hold_ticks ticks have passed since the last one, else a changed
// speed. Commands never produce a result. Rate: one item per clock but for a
// held tick as below; an item is registered in the input register, is processed
// in a single pass, and its result is registered in the output register.
// A tick waits in the input register only while a result is still held in
// the output register and rsp_ch is not ready; commands pass regardless.
// engine_count above MAX_ENGINES is clamped. csr_* writes must come while
// the block is idle. No clearing pass: the block is ready right after reset.
module thruster_mix_reverse_scheduler #(
   parameter int MAX_ENGINES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tmrs_req_if.sink                             req_ch,
   tmrs_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [tmrs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tmrs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tmrs_pkg::*;

   // control registers
   logic [ENG_CNT_W-1:0]  eng_cnt_ff;
   logic [HOLD_W-1:0]     hold_ff;
   logic [SRV_W-1:0]      served;

   // input register
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_item_type          s1_item_ff;
   req_item_type          req_item;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_item_type          rsp_item_ff;

   logic                  slot_free;
   logic                  proc_go;
   logic                  cmd_go;
   logic                  tick_go;
   logic                  emit;
   rsp_item_type          sched_item;
   logic [SPEED_W-1:0]    tgt_speed [MAX_ENGINES];
   logic                  tgt_rev   [MAX_ENGINES];

   // --- configuration ---
   always_ff @(posedge clock) begin
      if (reset) begin
         eng_cnt_ff <= ENG_CNT_RST;
         hold_ff    <= HOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENGINE_COUNT: eng_cnt_ff <= csr_wdata[ENG_CNT_W-1:0];
            CSR_HOLD_TICKS:   hold_ff    <= csr_wdata[HOLD_W-1:0];
            default:          ;
         endcase
      end
   end

   // engines served, clamped to what the arrays hold
   assign served = ({1'b0, eng_cnt_ff} > SRV_W'(MAX_ENGINES)) ?
                   SRV_W'(MAX_ENGINES) : {1'b0, eng_cnt_ff};

   // --- flow control ---
   // A tick may need the output register; a command never does.
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign proc_go   = s1_valid_ff && ((s1_item_ff.op == OP_COMMAND) || slot_free);
   assign cmd_go    = proc_go && (s1_item_ff.op == OP_COMMAND);
   assign tick_go   = proc_go && (s1_item_ff.op == OP_TICK);

   assign req_ch.ready = !s1_valid_ff || proc_go;

   assign req_item.op             = req_ch.op;
   assign req_item.mode           = req_ch.mode;
   assign req_item.vertical_speed = req_ch.vertical_speed;
   assign req_item.move_speed     = req_ch.move_speed;
   assign req_item.rotate_speed   = req_ch.rotate_speed;

   assign s1_valid_in  = (req_ch.valid && req_ch.ready) || (s1_valid_ff && !proc_go);
   assign rsp_valid_in = (proc_go && emit) || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         s1_item_ff <= req_item;
      end
      if (proc_go && emit) begin
         rsp_item_ff <= sched_item;
      end
   end

   // --- datapath ---
   tmrs_mix #(
      .MAX_ENGINES (MAX_ENGINES)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .cmd_go    (cmd_go),
      .cmd       (s1_item_ff),
      .served    (served),
      .tgt_speed (tgt_speed),
      .tgt_rev   (tgt_rev)
   );

   tmrs_sched #(
      .MAX_ENGINES (MAX_ENGINES)
   ) u_sched (
      .clock      (clock),
      .reset      (reset),
      .tick_go    (tick_go),
      .served     (served),
      .hold_ticks (hold_ff),
      .tgt_speed  (tgt_speed),
      .tgt_rev    (tgt_rev),
      .emit       (emit),
      .item       (sched_item)
   );

   // --- result channel ---
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.write_kind   = rsp_item_ff.write_kind;
   assign rsp_ch.engine_index = rsp_item_ff.engine_index;
   assign rsp_ch.write_value  = rsp_item_ff.write_value;

`ifndef NO_ASSERTIONS
   // a tick blocked by a waiting result stays in the input register untouched
   a_tick_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_item_ff.op == OP_TICK) && rsp_valid_ff && !rsp_ch.ready)
      |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("blocked tick left the input register");

   // every result of a processed tick reaches the output register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (proc_go && emit) |=> rsp_valid_ff)
      else $error("scheduled write lost");

   // a command leaves the output register as it was
   a_cmd_silent: assert property (@(posedge clock) disable iff (reset)
      cmd_go |=> (rsp_valid_ff == ($past(rsp_valid_ff) && !$past(rsp_ch.ready))))
      else $error("command produced a write");

   // direction writes carry a single bit
   a_dir_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_item_ff.write_kind == KIND_DIRECTION))
      |-> (rsp_item_ff.write_value[SPEED_W-1:1] == '0))
      else $error("direction write out of range");
`endif

endmodule

### hdl/tmrs_mix.sv
module tmrs_mix #(
   parameter int MAX_ENGINES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_go,
   input  tmrs_pkg::req_item_type             cmd,
   input  logic [tmrs_pkg::SRV_W-1:0]         served,
   output logic [tmrs_pkg::SPEED_W-1:0]       tgt_speed [MAX_ENGINES],
   output logic                               tgt_rev   [MAX_ENGINES]
);
   import tmrs_pkg::*;

   typedef struct packed {
      logic                     set;
      logic signed [MIX_W-1:0]  value;
   } drive_type;

   drive_type                 drv        [MAX_ENGINES];
   logic [SPEED_W-1:0]        tgt_speed_ff [MAX_ENGINES];
   logic [SPEED_W-1:0]        tgt_speed_in [MAX_ENGINES];
   logic                      tgt_rev_ff   [MAX_ENGINES];
   logic                      tgt_rev_in   [MAX_ENGINES];
   logic signed [MIX_W-1:0]   vs;
   logic signed [MIX_W-1:0]   ms;
   logic signed [MIX_W-1:0]   rs;
   logic signed [MIX_W-1:0]   mag;

   // Mixing: which engines get a new request and what value
   always_comb begin
      vs = MIX_W'($signed(cmd.vertical_speed));
      ms = MIX_W'($signed(cmd.move_speed));
      rs = MIX_W'($signed(cmd.rotate_speed));
      for (int i = 0; i < MAX_ENGINES; i++) begin
         drv[i] = '{set: 1'b0, value: '0};
      end
      if (cmd.mode == MODE_STOP) begin
         for (int i = 0; i < MAX_ENGINES; i++) begin
            drv[i] = '{set: 1'b1, value: '0};
         end
      end else begin
         drv[0] = '{set: 1'b1, value: vs};
         case (cmd.mode)
            MODE_YAW: begin
               drv[1] = '{set: 1'b1, value: rs};
               drv[2] = '{set: 1'b1, value: -rs};
            end
            default: begin
               if (!rs[MIX_W-1]) begin
                  drv[1] = '{set: 1'b1, value: ms - rs};
                  drv[2] = '{set: 1'b1, value: ms};
               end else begin
                  drv[1] = '{set: 1'b1, value: ms};
                  drv[2] = '{set: 1'b1, value: ms + rs};
               end
            end
         endcase
      end
   end

   // Out-of-range requests keep the old target
   always_comb begin
      mag = '0;
      for (int i = 0; i < MAX_ENGINES; i++) begin
         tgt_speed_in[i] = tgt_speed_ff[i];
         tgt_rev_in[i]   = tgt_rev_ff[i];
         mag = drv[i].value[MIX_W-1] ? -drv[i].value : drv[i].value;
         if (drv[i].set && (SRV_W'(i) < served) &&
             (drv[i].value >= -TARGET_LIMIT) && (drv[i].value <= TARGET_LIMIT)) begin
            tgt_speed_in[i] = mag[SPEED_W-1:0];
            tgt_rev_in[i]   = drv[i].value[MIX_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENGINES; i++) begin
            tgt_speed_ff[i] <= '0;
            tgt_rev_ff[i]   <= 1'b0;
         end
      end else if (cmd_go) begin
         for (int i = 0; i < MAX_ENGINES; i++) begin
            tgt_speed_ff[i] <= tgt_speed_in[i];
            tgt_rev_ff[i]   <= tgt_rev_in[i];
         end
      end
   end

   assign tgt_speed = tgt_speed_ff;
   assign tgt_rev   = tgt_rev_ff;

endmodule

### hdl/tmrs_sched.sv
module tmrs_sched #(
   parameter int MAX_ENGINES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tick_go,
   input  logic [tmrs_pkg::SRV_W-1:0]         served,
   input  logic [tmrs_pkg::HOLD_W-1:0]        hold_ticks,
   input  logic [tmrs_pkg::SPEED_W-1:0]       tgt_speed [MAX_ENGINES],
   input  logic                               tgt_rev   [MAX_ENGINES],
   output logic                               emit,
   output tmrs_pkg::rsp_item_type             item
);
   import tmrs_pkg::*;

   localparam int PTR_W = (MAX_ENGINES > 1) ? $clog2(MAX_ENGINES) : 1;

   logic [SPEED_W-1:0]  sent_speed_ff [MAX_ENGINES];
   logic                sent_rev_ff   [MAX_ENGINES];
   logic [HOLD_W-1:0]   hold_cnt_ff   [MAX_ENGINES];
   logic [HOLD_W-1:0]   cnt_inc       [MAX_ENGINES];
   logic [PTR_W-1:0]    ptr_ff;
   logic [PTR_W-1:0]    ptr_in;
   logic [PTR_W:0]      ptr_inc;
   logic                active;
   logic                dir_due;
   logic                spd_due;

   always_comb begin
      active  = tick_go && (served != '0);
      ptr_inc = {1'b0, ptr_ff} + 1'b1;
      ptr_in  = (SRV_W'(ptr_inc) >= served) ? '0 : ptr_inc[PTR_W-1:0];
      // saturating hold counters of the served engines
      for (int i = 0; i < MAX_ENGINES; i++) begin
         cnt_inc[i] = hold_cnt_ff[i];
         if ((SRV_W'(i) < served) && (hold_cnt_ff[i] != '1)) begin
            cnt_inc[i] = hold_cnt_ff[i] + 1'b1;
         end
      end
      dir_due = (cnt_inc[ptr_in] >= hold_ticks) && (tgt_rev[ptr_in] != sent_rev_ff[ptr_in]);
      spd_due = tgt_speed[ptr_in] != sent_speed_ff[ptr_in];
      emit    = active && (dir_due || spd_due);
      item.write_kind   = dir_due ? KIND_DIRECTION : KIND_SPEED;
      item.engine_index = ENG_IDX_W'(ptr_in);
      item.write_value  = dir_due ? SPEED_W'(tgt_rev[ptr_in]) : tgt_speed[ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         for (int i = 0; i < MAX_ENGINES; i++) begin
            sent_speed_ff[i] <= '0;
            sent_rev_ff[i]   <= 1'b0;
            hold_cnt_ff[i]   <= '0;
         end
      end else if (active) begin
         ptr_ff <= ptr_in;
         for (int i = 0; i < MAX_ENGINES; i++) begin
            hold_cnt_ff[i] <= cnt_inc[i];
            if (PTR_W'(i) == ptr_in) begin
               if (dir_due) begin
                  hold_cnt_ff[i] <= '0;
                  sent_rev_ff[i] <= tgt_rev[i];
               end else if (spd_due) begin
                  sent_speed_ff[i] <= tgt_speed[i];
               end
            end
         end
      end
   end

endmodule

### tb/sv/tmrs_write_checker.sv
module tmrs_write_checker #(
   parameter int MAX_ENGINES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   tmrs_req_if                             req_mon,
   tmrs_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [tmrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmrs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              outstanding,
   output int                              commands_seen,
   output int                              ticks_seen,
   output int                              speed_writes,
   output int                              direction_writes
);
   import tmrs_pkg::*;

   // mirrored control registers
   logic [ENG_CNT_W-1:0] eng_count;
   logic [HOLD_W-1:0]    hold_ticks;

   // mirrored engine state
   logic [SPEED_W-1:0]   tgt_speed  [MAX_ENGINES];
   logic                 tgt_rev    [MAX_ENGINES];
   logic [SPEED_W-1:0]   sent_speed [MAX_ENGINES];
   logic                 sent_rev   [MAX_ENGINES];
   logic [HOLD_W-1:0]    since_rev  [MAX_ENGINES];
   int unsigned          rr_ptr;

   rsp_item_type         writes_due[$];

   initial begin
      mismatches       = 0;
      outstanding      = 0;
      commands_seen    = 0;
      ticks_seen       = 0;
      speed_writes     = 0;
      direction_writes = 0;
   end

   function automatic int unsigned served_engines();
      return (eng_count > MAX_ENGINES) ? MAX_ENGINES : eng_count;
   endfunction

   // out-of-range targets are dropped, old target kept
   function void set_target(input int speed, input int unsigned eng);
      if (eng >= served_engines())
         return;
      if (speed >= -TARGET_LIMIT && speed < 0) begin
         tgt_speed[eng] = SPEED_W'(-speed);
         tgt_rev[eng]   = 1'b1;
      end else if (speed >= 0 && speed <= TARGET_LIMIT) begin
         tgt_speed[eng] = SPEED_W'(speed);
         tgt_rev[eng]   = 1'b0;
      end
   endfunction

   function void mix_command(input mode_type m, input int vs, input int ms, input int rs);
      set_target(vs, 0);
      case (m)
         MODE_STOP: begin
            for (int i = 0; i < served_engines(); i++)
               set_target(0, i);
         end
         MODE_YAW: begin
            set_target(rs, 1);
            set_target(-rs, 2);
         end
         default: begin
            // move and pitch mix the same way
            if (rs >= 0) begin
               set_target(ms - rs, 1);
               set_target(ms, 2);
            end else begin
               set_target(ms, 1);
               set_target(ms + rs, 2);
            end
         end
      endcase
   endfunction

   function void schedule_tick();
      int unsigned  n;
      int unsigned  e;
      rsp_item_type w;
      n = served_engines();
      if (n == 0)
         return;
      for (int i = 0; i < n; i++)
         if (since_rev[i] != '1)
            since_rev[i]++;
      rr_ptr++;
      if (rr_ptr >= n)
         rr_ptr = 0;
      e = rr_ptr;
      w.engine_index = ENG_IDX_W'(e);
      if (since_rev[e] >= hold_ticks && tgt_rev[e] != sent_rev[e]) begin
         since_rev[e]  = '0;
         sent_rev[e]   = tgt_rev[e];
         w.write_kind  = KIND_DIRECTION;
         w.write_value = SPEED_W'(sent_rev[e]);
         writes_due.push_back(w);
      end else if (tgt_speed[e] != sent_speed[e]) begin
         sent_speed[e] = tgt_speed[e];
         w.write_kind  = KIND_SPEED;
         w.write_value = sent_speed[e];
         writes_due.push_back(w);
      end
   endfunction

   task report(input string msg);
      $display("%0t: write mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task check_write(input rsp_item_type got);
      rsp_item_type want;
      if (writes_due.size() == 0) begin
         report($sformatf("unexpected write kind %0d engine %0d value %0d",
                          got.write_kind, got.engine_index, got.write_value));
         return;
      end
      want = writes_due.pop_front();
      if (got.write_kind !== want.write_kind)
         report($sformatf("write_kind %0d, expected %0d", got.write_kind, want.write_kind));
      if (got.engine_index !== want.engine_index)
         report($sformatf("engine_index %0d, expected %0d",
                          got.engine_index, want.engine_index));
      if (got.write_value !== want.write_value)
         report($sformatf("write_value %0d, expected %0d (engine %0d)",
                          got.write_value, want.write_value, want.engine_index));
      if (want.write_kind == KIND_DIRECTION)
         direction_writes++;
      else
         speed_writes++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         eng_count  = ENG_CNT_RST;
         hold_ticks = HOLD_RST;
         for (int i = 0; i < MAX_ENGINES; i++) begin
            tgt_speed[i]  = '0;
            tgt_rev[i]    = 1'b0;
            sent_speed[i] = '0;
            sent_rev[i]   = 1'b0;
            since_rev[i]  = '0;
         end
         rr_ptr = 0;
         writes_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENGINE_COUNT: eng_count  = csr_wdata[ENG_CNT_W-1:0];
               CSR_HOLD_TICKS:   hold_ticks = csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.op == OP_TICK) begin
               ticks_seen++;
               schedule_tick();
            end else begin
               commands_seen++;
               mix_command(req_mon.mode, signed'(req_mon.vertical_speed),
                           signed'(req_mon.move_speed), signed'(req_mon.rotate_speed));
            end
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            check_write({rsp_mon.write_kind, rsp_mon.engine_index, rsp_mon.write_value});
      end
      outstanding <= writes_due.size();
   end

endmodule

### tb/sv/tb_thruster_mix_reverse_scheduler.sv
module tb_thruster_mix_reverse_scheduler;
   import tmrs_pkg::*;

   localparam int ENGINES = 8;

   // idle mixes, percent of cycles
   localparam int IDLE_HEAVY = 76;
   localparam int IDLE_LIGHT = 9;

   // long receiver hold-off, in cycles
   localparam int LONG_STALL = 300;

   // cycles allowed for a tick still in flight with no write to show for it;
   // an item passes the block's input register, then its output register
   localparam int SETTLE_CYCLES = 6;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int idle_pct  = 0;   // sender idles in this share of cycles
   int stall_pct = 0;   // receiver stalls in this share of cycles
   logic long_stall = 1'b0;
   event hold_off_go;

   int mismatches;
   int outstanding;
   int commands_seen;
   int ticks_seen;
   int speed_writes;
   int direction_writes;

   tmrs_req_if req_ch ();
   tmrs_rsp_if rsp_ch ();

   thruster_mix_reverse_scheduler #(
      .MAX_ENGINES (ENGINES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // watches both channels and the register port, predicts every write
   tmrs_write_checker #(
      .MAX_ENGINES (ENGINES)
   ) write_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .commands_seen    (commands_seen),
      .ticks_seen       (ticks_seen),
      .speed_writes     (speed_writes),
      .direction_writes (direction_writes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      rsp_ch.ready <= !long_stall && ($urandom_range(99) >= stall_pct);
   end

   // Long hold-off is timed here so the sender keeps offering meanwhile;
   // with ticks queued behind a held write, the block stalls its input.
   initial begin
      forever begin
         @(hold_off_go);
         @(posedge clock);
         long_stall <= 1'b1;
         repeat (LONG_STALL) @(posedge clock);
         long_stall <= 1'b0;
      end
   end

   // Hard stop.
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic req_item_type command(input mode_type m, input int vs,
                                            input int ms, input int rs);
      req_item_type it;
      it.op             = OP_COMMAND;
      it.mode           = m;
      it.vertical_speed = REQ_SPD_W'(vs);
      it.move_speed     = REQ_SPD_W'(ms);
      it.rotate_speed   = REQ_SPD_W'(rs);
      return it;
   endfunction

   function automatic req_item_type tick_item();
      req_item_type it;
      it = '0;
      it.op             = OP_TICK;
      it.vertical_speed = REQ_SPD_W'($urandom);   // payload is don't-care on a tick
      it.rotate_speed   = REQ_SPD_W'($urandom);
      return it;
   endfunction

   // any op, any mode, any 10-bit pattern in every speed field
   function automatic req_item_type raw_item();
      req_item_type it;
      it.op             = op_type'($urandom_range(1));
      it.mode           = mode_type'($urandom_range(3));
      it.vertical_speed = REQ_SPD_W'($urandom);
      it.move_speed     = REQ_SPD_W'($urandom);
      it.rotate_speed   = REQ_SPD_W'($urandom);
      return it;
   endfunction

   // mostly legal targets, some over the +/-255 limit
   function automatic int pick_speed();
      if ($urandom_range(99) < 70)
         return int'($urandom_range(510)) - TARGET_LIMIT;
      return int'(signed'(REQ_SPD_W'($urandom)));
   endfunction

   function automatic req_item_type random_command();
      return command(mode_type'($urandom_range(3)), pick_speed(), pick_speed(),
                     pick_speed());
   endfunction

   // Sender. valid is held across back-to-back transfers and only lowered
   // when a gap is taken, so it sees one update per time step.
   task automatic send_item(input req_item_type it);
      if ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_ch.valid          <= 1'b1;
      req_ch.op             <= it.op;
      req_ch.mode           <= it.mode;
      req_ch.vertical_speed <= it.vertical_speed;
      req_ch.move_speed     <= it.move_speed;
      req_ch.rotate_speed   <= it.rotate_speed;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Pause until every predicted write has landed, plus the pipeline depth
   // so a silent tick is also out of the block.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back; only called with the block idle
   task automatic write_config(input int count, input int hold);
      csr_we    <= 1'b1;
      csr_index <= CSR_ENGINE_COUNT;
      csr_wdata <= CSR_DATA_W'(count);
      @(posedge clock);
      csr_index <= CSR_HOLD_TICKS;
      csr_wdata <= CSR_DATA_W'(hold);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One setting: mostly a command followed by a burst of ticks so the
   // round robin drains the new targets; the rest is raw noise.
   task automatic run_phase(input int count, input int hold, input int sidle,
                            input int rstall, input int n_items, input bit squeeze);
      int sent;
      int burst;
      idle_pct  = sidle;
      stall_pct = rstall;
      write_config(count, hold);
      if (squeeze)
         -> hold_off_go;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 12) begin
            send_item(raw_item());
            sent++;
         end else begin
            send_item(random_command());
            sent++;
            burst = $urandom_range(1, 10);
            repeat (burst) begin
               send_item(tick_item());
               sent++;
            end
         end
      end
      settle();
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_ENGINE_COUNT;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.op             = OP_COMMAND;
      req_ch.mode           = MODE_STOP;
      req_ch.vertical_speed = '0;
      req_ch.move_speed     = '0;
      req_ch.rotate_speed   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, at reset settings (3 engines, long hold-off).
      send_item(tick_item());                             // nothing pending
      send_item(command(MODE_MOVE, 255, 255, 0));         // full forward everywhere
      repeat (3) send_item(tick_item());
      send_item(command(MODE_PITCH, -255, 100, -100));    // pitch mixes like move
      repeat (3) send_item(tick_item());
      send_item(command(MODE_YAW, 0, 0, 255));            // engines 1/2 opposed
      send_item(command(MODE_YAW, -256, 0, -256));        // just past the limit: dropped
      send_item(command(MODE_MOVE, 511, 255, -511));      // engine 2 sum out of range
      send_item(command(MODE_MOVE, -512, -512, 511));     // all out of range
      repeat (3) send_item(tick_item());
      send_item(command(MODE_STOP, -100, 300, -300));     // stop overrides vertical
      repeat (3) send_item(tick_item());
      send_item(command(MODE_YAW, 1, -1, -1));
      repeat (3) send_item(tick_item());
      settle();

      // Random phases over engine count and hold-off, cycling the idle mixes.
      // First one also parks the receiver for a long stretch.
      run_phase(3, 1, 0, 0, 120, 1'b1);
      run_phase(8, 2, IDLE_HEAVY, 0, 130, 1'b0);
      run_phase(1, 0, 0, IDLE_HEAVY, 100, 1'b0);            // zero hold: always allowed
      run_phase(15, 3, IDLE_LIGHT, IDLE_LIGHT, 120, 1'b0);  // clamps to max engines
      run_phase(4, 1, 0, 0, 100, 1'b0);                     // pointer may wrap early
      run_phase(0, 1, IDLE_HEAVY, 0, 60, 1'b0);             // no engines: all silent
      run_phase(2, 5, 0, IDLE_HEAVY, 120, 1'b0);
      run_phase(8, 1, IDLE_LIGHT, IDLE_LIGHT, 150, 1'b0);
      run_phase(5, 2000, 0, 0, 100, 1'b0);
      run_phase(3, 4, IDLE_HEAVY, IDLE_HEAVY, 100, 1'b0);

      $display("covered %0d commands and %0d ticks across 11 engine-count/hold settings",
               commands_seen, ticks_seen);
      $display("checked %0d speed writes and %0d direction writes, %0d mismatches",
               speed_writes, direction_writes, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
